// File: src/xor_linear_basis_insert_defines.svh
// Assertion macros shared by the XOR linear basis block.
`ifndef XOR_LINEAR_BASIS_INSERT_DEFINES_SVH
`define XOR_LINEAR_BASIS_INSERT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define XLB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define XLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/xlb_pkg.sv
// Shared types and constants of the XOR linear basis block.
`timescale 1ns / 1ps
package xlb_pkg;

  localparam int VEC_W  = 32;
  localparam int IDX_W  = 5;
  localparam int PIV_W  = 5;
  localparam int RANK_W = 6;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_READ   = 1'b1
  } req_kind_e;

  // Control that travels with the reduction token down the cell chain.
  typedef struct packed {
    logic vld;
    logic found;
  } dn_ctl_t;

endpackage

// File: src/xlb_req_if.sv
// Request channel of the XOR linear basis block.
`timescale 1ns / 1ps
interface xlb_req_if import xlb_pkg::*; ();
  logic             valid;
  logic             ready;
  req_kind_e        req_type;
  logic [VEC_W-1:0] vec_value;
  logic [IDX_W-1:0] row_index;

  modport source (output valid, req_type, vec_value, row_index, input ready);
  modport sink   (input valid, req_type, vec_value, row_index, output ready);
endinterface

// File: src/xlb_res_if.sv
// Result channel of the XOR linear basis block.
`timescale 1ns / 1ps
interface xlb_res_if import xlb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              independent;
  logic [PIV_W-1:0]  pivot_pos;
  logic [RANK_W-1:0] basis_rank;
  logic [VEC_W-1:0]  row_out;

  modport source (output valid, independent, pivot_pos, basis_rank, row_out, input ready);
  modport sink   (input valid, independent, pivot_pos, basis_rank, row_out, output ready);
endinterface

// File: src/xlb_cell.sv
// One basis cell: holds the row of one pivot bit and forwards the tokens.
`timescale 1ns / 1ps
module xlb_cell import xlb_pkg::*; #(
  parameter int BITS = 32,
  parameter int IDX  = 0,
  localparam int PW  = (BITS > 1) ? $clog2(BITS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dn_ctl_t         dn_ctl_i,
  input  logic [BITS-1:0] dn_vec_i,
  input  logic [PW-1:0]   dn_piv_i,
  output dn_ctl_t         dn_ctl_o,
  output logic [BITS-1:0] dn_vec_o,
  output logic [PW-1:0]   dn_piv_o,
  input  logic            up_vld_i,
  input  logic [BITS-1:0] up_vec_i,
  input  logic [PW-1:0]   up_piv_i,
  output logic            up_vld_o,
  output logic [BITS-1:0] up_vec_o,
  output logic [PW-1:0]   up_piv_o,
  output logic [BITS-1:0] row_o
);

  localparam logic [PW-1:0] CellIdx = PW'(IDX);

  logic [BITS-1:0] row_q, row_d;
  dn_ctl_t         dn_ctl_q;
  logic [BITS-1:0] dn_vec_q, vec_x;
  logic [PW-1:0]   dn_piv_q;
  logic            up_vld_q;
  logic [BITS-1:0] up_vec_q;
  logic [PW-1:0]   up_piv_q;
  logic            hit;

  // An empty row is zero, so the XOR needs no separate valid bit.
  assign vec_x = dn_vec_i[IDX] ? (dn_vec_i ^ row_q) : dn_vec_i;
  // Bits at and above this cell are final here; the first one left set is the pivot.
  assign hit   = !dn_ctl_i.found && vec_x[IDX];

  always_comb begin
    row_d = row_q;
    if (up_vld_i) begin
      if (up_piv_i == CellIdx) begin
        row_d = up_vec_i;
      end else if ((CellIdx > up_piv_i) && row_q[up_piv_i]) begin
        row_d = row_q ^ up_vec_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      dn_ctl_q <= '0;
      up_vld_q <= 1'b0;
    end else begin
      row_q          <= row_d;
      dn_ctl_q.vld   <= dn_ctl_i.vld;
      dn_ctl_q.found <= dn_ctl_i.found || hit;
      up_vld_q       <= up_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dn_vec_q <= vec_x;
    dn_piv_q <= hit ? CellIdx : dn_piv_i;
    up_vec_q <= up_vec_i;
    up_piv_q <= up_piv_i;
  end

  assign dn_ctl_o = dn_ctl_q;
  assign dn_vec_o = dn_vec_q;
  assign dn_piv_o = dn_piv_q;
  assign up_vld_o = up_vld_q;
  assign up_vec_o = up_vec_q;
  assign up_piv_o = up_piv_q;
  assign row_o    = row_q;

endmodule

// File: src/xor_linear_basis_insert.sv
// Top level of the reduced XOR linear basis with insert and row read.
//
//   Channel  Direction  Carries
//   req_i    in         req_type, vec_value, row_index
//   res_o    out        independent, pivot_pos, basis_rank, row_out
//
// A read result is registered in the finish register, then in the output register.
// An insert walks the cell chain downward; a dependent vector finishes at cell 0, an
// independent one makes a second pass back up the chain before it finishes. Only one
// token travels through the chain at a time.
// Reset clears every basis row and the rank at once; no clearing pass is needed.
// A new transaction is accepted as soon as the previous result has moved into the output
// register, so a stalled result sink holds at most one finished result plus one in work.
`timescale 1ns / 1ps
`include "xor_linear_basis_insert_defines.svh"
module xor_linear_basis_insert import xlb_pkg::*; #(
  parameter int BITS = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  xlb_req_if.sink   req_i,
  xlb_res_if.source res_o
);

  localparam int PW = (BITS > 1) ? $clog2(BITS) : 1;

  // Down chain: element k feeds cell k-1; element BITS is the launch point.
  dn_ctl_t         dn_ctl [BITS+1];
  logic [BITS-1:0] dn_vec [BITS+1];
  logic [PW-1:0]   dn_piv [BITS+1];
  // Up chain: element k feeds cell k; element BITS is the exit.
  logic            up_vld [BITS+1];
  logic [BITS-1:0] up_vec [BITS+1];
  logic [PW-1:0]   up_piv [BITS+1];
  logic [BITS-1:0] rows   [BITS];

  logic              busy_q;
  logic [RANK_W-1:0] rank_q;
  logic              fin_vld_q;
  logic              fin_indep_q;
  logic [PIV_W-1:0]  fin_piv_q;
  logic [RANK_W-1:0] fin_rank_q;
  logic [VEC_W-1:0]  fin_row_q;
  logic              out_vld_q;
  logic              out_indep_q;
  logic [PIV_W-1:0]  out_piv_q;
  logic [RANK_W-1:0] out_rank_q;
  logic [VEC_W-1:0]  out_row_q;

  logic              req_acc;
  logic              rd_now;
  logic              dep_done;
  logic              ind_done;
  logic              fin_move;
  logic [BITS-1:0]   rd_row;
  logic [2*BITS:0]   tok_vec;

  assign req_i.ready = !busy_q;
  assign req_acc     = req_i.valid && !busy_q;
  assign rd_now      = req_acc && (req_i.req_type == REQ_READ);

  // An accepted insert enters the top cell at the same edge, masked to BITS coordinates.
  assign dn_ctl[BITS].vld   = req_acc && (req_i.req_type == REQ_INSERT);
  assign dn_ctl[BITS].found = 1'b0;
  assign dn_vec[BITS]       = BITS'(req_i.vec_value);
  assign dn_piv[BITS]       = '0;

  // When the remainder leaves cell 0 nonzero, it turns around and climbs the chain:
  // the pivot cell stores it and every higher row holding the pivot bit drops it.
  assign up_vld[0] = dn_ctl[0].vld && dn_ctl[0].found;
  assign up_vec[0] = dn_vec[0];
  assign up_piv[0] = dn_piv[0];

  for (genvar i = 0; i < BITS; i++) begin : g_cell
    xlb_cell #(
      .BITS (BITS),
      .IDX  (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .dn_ctl_i (dn_ctl[i+1]),
      .dn_vec_i (dn_vec[i+1]),
      .dn_piv_i (dn_piv[i+1]),
      .dn_ctl_o (dn_ctl[i]),
      .dn_vec_o (dn_vec[i]),
      .dn_piv_o (dn_piv[i]),
      .up_vld_i (up_vld[i]),
      .up_vec_i (up_vec[i]),
      .up_piv_i (up_piv[i]),
      .up_vld_o (up_vld[i+1]),
      .up_vec_o (up_vec[i+1]),
      .up_piv_o (up_piv[i+1]),
      .row_o    (rows[i])
    );
  end

  // A read beyond the last coordinate returns an empty row.
  assign rd_row = (int'(req_i.row_index) < BITS) ? rows[PW'(req_i.row_index)] : '0;

  assign dep_done = dn_ctl[0].vld && !dn_ctl[0].found;
  assign ind_done = up_vld[BITS];
  assign fin_move = fin_vld_q && (!out_vld_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      rank_q    <= '0;
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (req_acc) begin
        busy_q <= 1'b1;
      end else if (fin_move) begin
        busy_q <= 1'b0;
      end

      if (ind_done) begin
        rank_q <= rank_q + RANK_W'(1);
      end

      if (rd_now || ind_done || dep_done) begin
        fin_vld_q <= 1'b1;
      end else if (fin_move) begin
        fin_vld_q <= 1'b0;
      end

      if (fin_move) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Only one transaction is ever in work, so at most one of these conditions holds.
  always_ff @(posedge clk_i) begin
    if (rd_now) begin
      fin_indep_q <= 1'b0;
      fin_piv_q   <= '0;
      fin_rank_q  <= rank_q;
      fin_row_q   <= VEC_W'(rd_row);
    end else if (ind_done) begin
      fin_indep_q <= 1'b1;
      fin_piv_q   <= PIV_W'(up_piv[BITS]);
      fin_rank_q  <= rank_q + RANK_W'(1);
      fin_row_q   <= VEC_W'(up_vec[BITS]);
    end else if (dep_done) begin
      fin_indep_q <= 1'b0;
      fin_piv_q   <= '0;
      fin_rank_q  <= rank_q;
      fin_row_q   <= '0;
    end

    if (fin_move) begin
      out_indep_q <= fin_indep_q;
      out_piv_q   <= fin_piv_q;
      out_rank_q  <= fin_rank_q;
      out_row_q   <= fin_row_q;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.independent = out_indep_q;
  assign res_o.pivot_pos   = out_piv_q;
  assign res_o.basis_rank  = out_rank_q;
  assign res_o.row_out     = out_row_q;

  // Every place a transaction can sit between acceptance and the output register.
  always_comb begin
    tok_vec[0] = fin_vld_q;
    for (int k = 0; k < BITS; k++) begin
      tok_vec[2*k+1] = dn_ctl[k].vld;
      tok_vec[2*k+2] = up_vld[k+1];
    end
  end

  `XLB_ASSERT_IMPLY(a_one_token, 1'b1, $onehot0(tok_vec), "more than one transaction in work")
  `XLB_ASSERT_IMPLY(a_idle_empty, !busy_q, tok_vec == '0, "token in work while not busy")
  `XLB_ASSERT_NEXT(a_rank_step, ind_done, rank_q == $past(rank_q) + RANK_W'(1), "rank not raised")
  `XLB_ASSERT_IMPLY(a_rank_bound, 1'b1, rank_q <= RANK_W'(BITS), "rank above vector width")

endmodule
